// ===== design/pip_pkg.sv =====
// ============================================================================
// pip_pkg
// Shared constants, register map and control/status types of the
// point-in-polygon test core.
// ============================================================================
package pip_pkg;

    // table and coordinate geometry
    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int MIN_VERTICES = 3;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 6;
    localparam int VTX_W        = 2 * COORD_BITS;

    // register widths
    localparam int CNT_W  = 7;
    localparam int FUZZ_W = 10;

    // arithmetic widths
    localparam int DIFF_W = COORD_BITS + 1;      // difference of two coordinates
    localparam int SPAN_W = DIFF_W + 1;          // x span, kept signed
    localparam int PROD_W = DIFF_W + SPAN_W;     // cross product term
    localparam int SQ_W   = 2 * FUZZ_W;          // squared distance term

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FUZZ_RADIUS  = 1'b1;

    // request operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic start;      // new query: latch point, clear accumulators
        logic rd_en;      // table read issued this cycle
        logic rd_first;   // read fetches the closing vertex (previous of first)
    } pip_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;       // vertex still in flight in the pipeline
        logic in_poly;    // vertex hit or odd crossing count so far
    } pip_stat_t;

endpackage

// ===== design/pip_ram.sv =====
// ============================================================================
// pip_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pip_dp.sv =====
// ============================================================================
// pip_dp
// Vertex datapath: edge setup, cross-product and distance multiplies,
// compare and crossing-parity accumulation, one vertex per cycle.
// ============================================================================
module pip_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pip_pkg::pip_cmd_t                     cmd,
    input  logic signed [pip_pkg::COORD_BITS-1:0] s_coord_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] s_coord_y,
    input  logic [pip_pkg::FUZZ_W-1:0]            fuzz_radius,
    input  logic [pip_pkg::VTX_W-1:0]             rd_data,
    output pip_pkg::pip_stat_t                    stat
);

    localparam int CB = pip_pkg::COORD_BITS;
    localparam int DW = pip_pkg::DIFF_W;
    localparam int SW = pip_pkg::SPAN_W;
    localparam int PW = pip_pkg::PROD_W;
    localparam int FW = pip_pkg::FUZZ_W;
    localparam int QW = pip_pkg::SQ_W;

    // query point and previous vertex
    logic signed [CB-1:0] qx_reg, qy_reg, ox_reg, oy_reg;
    // read data stage tags
    logic v1_reg, f1_reg;
    // stage A: edge setup
    logic                 va_reg, conda_reg, neara_reg;
    logic signed [DW-1:0] a_reg, c_reg;
    logic signed [SW-1:0] b_reg, d_reg;
    logic [FW-1:0]        adx_reg, ady_reg;
    // stage B: products
    logic                 vb_reg, condb_reg, nearb_reg;
    logic signed [PW-1:0] pa_reg, pc_reg;
    logic [QW-1:0]        sqx_reg, sqy_reg;
    // accumulators
    logic                 odd_reg, hit_reg;
    logic [QW-1:0]        fuzz_sq_reg;

    // stage A combinational
    logic signed [CB-1:0] nx, ny, x1, y1, x2, y2;
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx, ady;
    logic                 swap, cond, near_ok;
    logic [QW:0]          dist_sum;

    always_comb begin
        nx      = signed'(rd_data[pip_pkg::VTX_W-1:CB]);
        ny      = signed'(rd_data[CB-1:0]);
        dx      = DW'(qx_reg) - DW'(nx);
        dy      = DW'(qy_reg) - DW'(ny);
        adx     = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady     = dy[DW-1] ? DW'(-dy) : DW'(dy);
        near_ok = (adx < DW'(fuzz_radius)) && (ady < DW'(fuzz_radius));
        swap    = nx > ox_reg;
        x1      = swap ? ox_reg : nx;
        y1      = swap ? oy_reg : ny;
        x2      = swap ? nx : ox_reg;
        y2      = swap ? ny : oy_reg;
        // half-open rule: the point's x lies in (x1, x2]
        cond    = (nx < qx_reg) == (qx_reg <= ox_reg);
    end

    assign dist_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            odd_reg <= 1'b0;
            hit_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            va_reg <= v1_reg && !f1_reg;
            vb_reg <= va_reg;
            if (cmd.start) begin
                odd_reg <= 1'b0;
                hit_reg <= 1'b0;
            end else if (vb_reg) begin
                if (nearb_reg && (dist_sum < {1'b0, fuzz_sq_reg})) begin
                    hit_reg <= 1'b1;
                end
                if (condb_reg && (pa_reg < pc_reg)) begin
                    odd_reg <= !odd_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        f1_reg      <= cmd.rd_first;
        fuzz_sq_reg <= QW'(fuzz_radius) * QW'(fuzz_radius);
        if (cmd.start) begin
            qx_reg <= s_coord_x;
            qy_reg <= s_coord_y;
        end
        if (v1_reg) begin
            ox_reg <= nx;
            oy_reg <= ny;
        end
        // stage A
        conda_reg <= cond;
        neara_reg <= near_ok;
        adx_reg   <= adx[FW-1:0];
        ady_reg   <= ady[FW-1:0];
        a_reg     <= DW'(qy_reg) - DW'(y1);
        c_reg     <= DW'(y2) - DW'(y1);
        b_reg     <= SW'(x2) - SW'(x1);
        d_reg     <= SW'(qx_reg) - SW'(x1);
        // stage B
        condb_reg <= conda_reg;
        nearb_reg <= neara_reg;
        pa_reg    <= PW'(a_reg) * PW'(b_reg);
        pc_reg    <= PW'(c_reg) * PW'(d_reg);
        sqx_reg   <= QW'(adx_reg) * QW'(adx_reg);
        sqy_reg   <= QW'(ady_reg) * QW'(ady_reg);
    end

    assign stat.busy    = v1_reg | va_reg | vb_reg;
    assign stat.in_poly = hit_reg | odd_reg;

endmodule

// ===== design/pip_ctrl.sv =====
// ============================================================================
// pip_ctrl
// Query sequencer: accepts requests, walks the vertex table, waits for the
// datapath to drain and loads the result register.
// ============================================================================
module pip_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_operation,
    output logic                         in_ready,
    input  logic [pip_pkg::CNT_W-1:0]    vertex_count,
    output logic [pip_pkg::ADDR_W-1:0]   rd_addr,
    output pip_pkg::pip_cmd_t            cmd,
    input  pip_pkg::pip_stat_t           stat,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_inside_res
);

    localparam int CW = pip_pkg::CNT_W;
    localparam int AW = pip_pkg::ADDR_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          first_reg, first_next;
    logic          short_reg, short_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_inside_reg, m_inside_next;

    logic [CW-1:0] n_eff;
    logic [AW-1:0] last_addr;
    logic          is_short, accept_q, out_free;

    always_comb begin
        n_eff = (vertex_count > CW'(pip_pkg::MAX_VERTICES)) ?
                CW'(pip_pkg::MAX_VERTICES) : vertex_count;
    end
    assign last_addr = AW'(n_eff - CW'(1));
    assign is_short  = n_eff < CW'(pip_pkg::MIN_VERTICES);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_q  = in_valid && in_ready && (in_operation == pip_pkg::OP_QUERY);
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        first_next    = first_reg;
        short_next    = short_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_inside_next = m_inside_reg;
        cmd.start     = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_first  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_q) begin
                    cmd.start  = 1'b1;
                    short_next = is_short;
                    addr_next  = last_addr;
                    first_next = 1'b1;
                    state_next = is_short ? ST_DRAIN : ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = first_reg;
                if (first_reg) begin
                    first_next = 1'b0;
                    addr_next  = '0;
                end else if (addr_reg == last_addr) begin
                    state_next = ST_DRAIN;
                end else begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN: begin
                if (!stat.busy && out_free) begin
                    m_valid_next  = 1'b1;
                    m_inside_next = !short_reg && stat.in_poly;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            first_reg   <= 1'b0;
            short_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            short_reg   <= short_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        m_inside_reg <= m_inside_next;
    end

    assign rd_addr      = addr_reg;
    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

    // a query never starts with a vertex still in the pipeline
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !stat.busy)
        else $error("query started while datapath busy");

    // walk opens on the closing vertex
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_q && !is_short) |=> (first_reg && (addr_reg == last_addr)))
        else $error("walk did not open on the closing vertex");

    // reads stay inside the polygon in use
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (addr_reg <= last_addr))
        else $error("vertex read beyond the polygon");

    // a drained query lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !stat.busy && out_free)
        |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("finished query not delivered");

endmodule

// ===== design/point_in_polygon_test_core.sv =====
// ============================================================================
// point_in_polygon_test_core
// Point-in-polygon tester with a vertex table written by index.
//
// Use:
//   - Configure vertex_count (addr 0x0) and fuzz_radius (addr 0x4) over the
//     APB port while the core is idle.
//   - Each s_ request is a vertex write (s_operation = 0, slot in
//     s_vertex_index) or a point query (s_operation = 1). Writes produce
//     nothing; each query yields one m_inside_res.
//   - A query of n vertices (n capped at the table size) reads n + 1 table
//     entries, one per cycle, starting with the closing vertex, and the
//     result register loads once the datapath has drained; no new request
//     is taken until then. Polygons under three vertices load a 0 result.
//   - Vertex writes are taken every cycle while no query is running, also
//     while a result waits in the output register.
//   - A stalled m_ready holds the result; a finished query then waits in
//     the datapath until the output register frees up.
//   - Reset clears both registers and the control state; table contents
//     are undefined until written.
// ============================================================================
module point_in_polygon_test_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [pip_pkg::PADDR_W-1:0]           paddr,
    input  logic [pip_pkg::PDATA_W-1:0]           pwdata,
    output logic [pip_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    // requests
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_operation,
    input  logic [pip_pkg::IDX_W-1:0]             s_vertex_index,
    input  logic signed [pip_pkg::COORD_BITS-1:0] s_coord_x,
    input  logic signed [pip_pkg::COORD_BITS-1:0] s_coord_y,
    // results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_inside_res
);

    localparam int CW = pip_pkg::CNT_W;
    localparam int FW = pip_pkg::FUZZ_W;
    localparam int DW = pip_pkg::PDATA_W;

    logic [CW-1:0] vertex_count_reg, vertex_count_next;
    logic [FW-1:0] fuzz_radius_reg, fuzz_radius_next;

    logic                                cfg_wr;
    logic [pip_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                tbl_we;
    logic [pip_pkg::ADDR_W-1:0]          rd_addr;
    logic [pip_pkg::VTX_W-1:0]           rd_data;
    pip_pkg::pip_cmd_t                   cmd;
    pip_pkg::pip_stat_t                  stat;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_comb begin
        vertex_count_next = vertex_count_reg;
        fuzz_radius_next  = fuzz_radius_reg;
        prdata            = '0;
        unique case (reg_idx)
            pip_pkg::REG_VERTEX_COUNT: begin
                prdata = DW'(vertex_count_reg);
                if (cfg_wr) begin
                    vertex_count_next = pwdata[CW-1:0];
                end
            end
            pip_pkg::REG_FUZZ_RADIUS: begin
                prdata = DW'(fuzz_radius_reg);
                if (cfg_wr) begin
                    fuzz_radius_next = pwdata[FW-1:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
            fuzz_radius_reg  <= '0;
        end else begin
            vertex_count_reg <= vertex_count_next;
            fuzz_radius_reg  <= fuzz_radius_next;
        end
    end

    // ---------------- vertex table ----------------
    // writes go straight in on acceptance; slots past the table are dropped
    assign tbl_we = s_valid && s_ready && (s_operation == pip_pkg::OP_WRITE) &&
                    ({1'b0, s_vertex_index} < (pip_pkg::IDX_W + 1)'(pip_pkg::MAX_VERTICES));

    pip_ram #(
        .WIDTH (pip_pkg::VTX_W),
        .DEPTH (pip_pkg::MAX_VERTICES)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (s_vertex_index[pip_pkg::ADDR_W-1:0]),
        .wdata ({s_coord_x, s_coord_y}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // ---------------- sequencer ----------------
    pip_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_operation (s_operation),
        .in_ready     (s_ready),
        .vertex_count (vertex_count_reg),
        .rd_addr      (rd_addr),
        .cmd          (cmd),
        .stat         (stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_inside_res (m_inside_res)
    );

    // ---------------- vertex datapath ----------------
    pip_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_coord_x   (s_coord_x),
        .s_coord_y   (s_coord_y),
        .fuzz_radius (fuzz_radius_reg),
        .rd_data     (rd_data),
        .stat        (stat)
    );

endmodule
